/* sv/tswc_pkg.sv */
// tswc_pkg: shared types and constants for the target sum way counter
// no dependencies; used by every module of the block but tswc_ram

package tswc_pkg;

    localparam int MAX_SUM   = 1023;
    localparam int MODULUS   = 1000000007;
    localparam int COUNT_W   = 30;
    localparam int NUM_W     = 10;
    localparam int TGT_W     = 11;
    localparam int TOTAL_W   = 20;
    localparam int ROW_DEPTH = MAX_SUM + 1;
    localparam int ADDR_W    = $clog2(ROW_DEPTH);
    localparam int CMP_W     = (ADDR_W > NUM_W) ? ADDR_W : NUM_W;
    localparam int SUM_W     = COUNT_W + 1;
    localparam int JW        = TOTAL_W + 2;
    localparam int NEED_W    = JW - 1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [CMP_W-1:0]   cmp_t;
    typedef logic [NEED_W-1:0]  need_t;
    typedef logic [SUM_W-1:0]   sum_t;

    localparam sum_t  MOD_SUM  = SUM_W'(MODULUS);
    localparam addr_t ADDR_TOP = ADDR_W'(MAX_SUM);
    localparam cmp_t  MAX_CMP  = CMP_W'(MAX_SUM);
    localparam need_t MAX_NEED = NEED_W'(MAX_SUM);

    typedef struct packed {
        logic [NUM_W-1:0] number_value;
        logic             last_number;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] way_count;
        logic               sum_too_large;
    } out_item_t;

    typedef struct packed {
        logic  flag;
        logic  zero;
        addr_t need_addr;
    } judge_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_DRAIN,
        S_JUDGE,
        S_READ,
        S_LOAD
    } state_t;

endpackage

/* sv/target_sum_way_counter.sv */
// target_sum_way_counter: counts signed sum assignments reaching a target, mod 1e9+7
// a number within the row walks the row from the top entry down (one row entry per cycle
// through the shared modular adder, two-read-port count ram); a larger number skips the walk
// the last number then goes through the judge, read and load states, then a clearing pass
// reset is synchronous active low and starts the same clearing pass
// depends on tswc_pkg, tswc_ram, tswc_mod_add, tswc_judge

module target_sum_way_counter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic signed [tswc_pkg::TGT_W-1:0]    cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  tswc_pkg::in_item_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output tswc_pkg::out_item_t                  m_data
);

    tswc_pkg::state_t state_reg, state_next;

    logic signed [tswc_pkg::TGT_W-1:0] target_reg;
    tswc_pkg::addr_t    addr_reg, addr_next;
    tswc_pkg::addr_t    v_addr_reg, v_addr_next;
    logic               last_reg, last_next;
    tswc_pkg::total_t   total_reg, total_next;
    logic               sat_reg, sat_next;
    logic               pend_reg;
    tswc_pkg::addr_t    wr_addr_reg;
    tswc_pkg::judge_t   judge_reg, judge_next;
    logic               m_valid_reg, m_valid_next;
    tswc_pkg::out_item_t m_data_reg, m_data_next;

    logic               accept;
    logic               v_in_row;
    logic [tswc_pkg::TOTAL_W:0] total_sum;
    logic               out_free;
    logic               ram_we;
    tswc_pkg::addr_t    ram_waddr;
    tswc_pkg::count_t   ram_wdata;
    tswc_pkg::addr_t    raddr_a;
    tswc_pkg::addr_t    raddr_b;
    tswc_pkg::count_t   rdata_a;
    tswc_pkg::count_t   rdata_b;
    tswc_pkg::count_t   add_sum;

    assign accept    = s_valid && s_ready;
    assign v_in_row  = tswc_pkg::cmp_t'(s_data.number_value) <= tswc_pkg::MAX_CMP;
    assign total_sum = {1'b0, total_reg} + (tswc_pkg::TOTAL_W + 1)'(s_data.number_value);
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    tswc_ram #(
        .WIDTH (tswc_pkg::COUNT_W),
        .DEPTH (tswc_pkg::ROW_DEPTH)
    ) u_row (
        .clk     (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    tswc_mod_add u_add (
        .a   (rdata_a),
        .b   (rdata_b),
        .sum (add_sum)
    );

    tswc_judge u_judge (
        .total     (total_reg),
        .saturated (sat_reg),
        .target    (target_reg),
        .judge     (judge_next)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tswc_pkg::S_CLEAR: begin
                if (addr_reg == tswc_pkg::ADDR_TOP) begin
                    state_next = tswc_pkg::S_IDLE;
                end
            end
            tswc_pkg::S_IDLE: begin
                if (accept) begin
                    if (v_in_row) begin
                        state_next = tswc_pkg::S_UPDATE;
                    end else if (s_data.last_number) begin
                        state_next = tswc_pkg::S_JUDGE;
                    end
                end
            end
            tswc_pkg::S_UPDATE: begin
                if (addr_reg == v_addr_reg) begin
                    state_next = tswc_pkg::S_DRAIN;
                end
            end
            tswc_pkg::S_DRAIN: state_next = last_reg ? tswc_pkg::S_JUDGE : tswc_pkg::S_IDLE;
            tswc_pkg::S_JUDGE: state_next = tswc_pkg::S_READ;
            tswc_pkg::S_READ:  state_next = tswc_pkg::S_LOAD;
            tswc_pkg::S_LOAD: begin
                if (out_free) begin
                    state_next = tswc_pkg::S_CLEAR;
                end
            end
            default: state_next = tswc_pkg::S_CLEAR;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        s_ready      = 1'b0;
        addr_next    = addr_reg;
        v_addr_next  = v_addr_reg;
        last_next    = last_reg;
        total_next   = total_reg;
        sat_next     = sat_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        raddr_a      = judge_reg.need_addr;
        raddr_b      = addr_reg - v_addr_reg;
        ram_we       = pend_reg;
        ram_waddr    = wr_addr_reg;
        ram_wdata    = add_sum;
        unique case (state_reg)
            tswc_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = (addr_reg == '0) ? tswc_pkg::count_t'(1) : '0;
                addr_next = addr_reg + 1'b1;
            end
            tswc_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    v_addr_next = tswc_pkg::addr_t'(s_data.number_value);
                    last_next   = s_data.last_number;
                    addr_next   = tswc_pkg::ADDR_TOP;
                    if (total_sum[tswc_pkg::TOTAL_W]) begin
                        total_next = '1;
                        sat_next   = 1'b1;
                    end else begin
                        total_next = total_sum[tswc_pkg::TOTAL_W-1:0];
                    end
                end
            end
            tswc_pkg::S_UPDATE: begin
                raddr_a = addr_reg;
                if (addr_reg != v_addr_reg) begin
                    addr_next = addr_reg - 1'b1;
                end
            end
            tswc_pkg::S_DRAIN, tswc_pkg::S_JUDGE, tswc_pkg::S_READ: begin
            end
            tswc_pkg::S_LOAD: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_data_next.way_count     = judge_reg.zero ? '0 : rdata_a;
                    m_data_next.sum_too_large = judge_reg.flag;
                    addr_next                 = '0;
                    total_next                = '0;
                    sat_next                  = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tswc_pkg::S_CLEAR;
            target_reg  <= '0;
            addr_reg    <= '0;
            total_reg   <= '0;
            sat_reg     <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_wr_en) begin
                target_reg <= cfg_wr_data;
            end
            addr_reg    <= addr_next;
            total_reg   <= total_next;
            sat_reg     <= sat_next;
            pend_reg    <= (state_reg == tswc_pkg::S_UPDATE);
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_addr_reg  <= v_addr_next;
        last_reg    <= last_next;
        wr_addr_reg <= addr_reg;
        m_data_reg  <= m_data_next;
        if (state_reg == tswc_pkg::S_JUDGE) begin
            judge_reg <= judge_next;
        end
    end

    // row update never writes below the number being absorbed
    a_upd_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && state_reg != tswc_pkg::S_CLEAR) |-> (wr_addr_reg >= v_addr_reg))
        else $error("row write below absorbed number");

    // a flagged item carries a zero count
    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.sum_too_large) |-> (m_data_reg.way_count == '0))
        else $error("flagged item with nonzero count");

    // counts stay reduced
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ({1'b0, m_data_reg.way_count} < tswc_pkg::MOD_SUM))
        else $error("count not reduced");

    // an in-row number starts a row walk from the top entry
    a_walk_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && v_in_row) |=>
            (state_reg == tswc_pkg::S_UPDATE && addr_reg == tswc_pkg::ADDR_TOP))
        else $error("row walk did not start");

endmodule

/* sv/tswc_ram.sv */
// tswc_ram: generic ram, one write port and two registered read ports
// no dependencies

module tswc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* sv/tswc_mod_add.sv */
// tswc_mod_add: modular adder shared by every row update
// depends on tswc_pkg

module tswc_mod_add (
    input  tswc_pkg::count_t a,
    input  tswc_pkg::count_t b,
    output tswc_pkg::count_t sum
);

    tswc_pkg::sum_t raw;
    tswc_pkg::sum_t red;

    always_comb begin
        raw = {1'b0, a} + {1'b0, b};
        red = raw - tswc_pkg::MOD_SUM;
        sum = (raw >= tswc_pkg::MOD_SUM) ? red[tswc_pkg::COUNT_W-1:0]
                                         : raw[tswc_pkg::COUNT_W-1:0];
    end

endmodule

/* sv/tswc_judge.sv */
// tswc_judge: turns running total and target into needed subset sum and flags
// depends on tswc_pkg

module tswc_judge (
    input  tswc_pkg::total_t          total,
    input  logic                      saturated,
    input  logic signed [tswc_pkg::TGT_W-1:0] target,
    output tswc_pkg::judge_t          judge
);

    logic signed [tswc_pkg::JW-1:0] t_w;
    logic signed [tswc_pkg::JW-1:0] tot_w;
    logic signed [tswc_pkg::JW-1:0] d_w;
    logic                           reach;
    logic                           odd;
    tswc_pkg::need_t                need;
    logic                           too_big;

    always_comb begin
        t_w     = tswc_pkg::JW'(target);
        tot_w   = signed'({2'b00, total});
        reach   = (t_w <= tot_w) && (-t_w <= tot_w);
        d_w     = tot_w + t_w;
        odd     = d_w[0];
        need    = d_w[tswc_pkg::JW-1:1];
        too_big = need > tswc_pkg::MAX_NEED;
        judge.flag      = saturated || (reach && !odd && too_big);
        judge.zero      = saturated || !reach || odd || too_big;
        judge.need_addr = need[tswc_pkg::ADDR_W-1:0];
    end

endmodule

/* verif/tb.sv */
// tb: self-checking bench for target_sum_way_counter with its own subset-count predictor
// walks a short table of sets, then random sets under several targets
// depends on tswc_pkg and target_sum_way_counter

module tb;

    localparam int TOTAL_MAX   = 2 ** tswc_pkg::TOTAL_W - 1;
    localparam int SETTLE      = tswc_pkg::MAX_SUM + 64;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 55;

    typedef struct packed {
        bit new_tgt;
        int tgt;
        int num;
        bit last;
        bit typed;
        int cnt;
        bit flag;
    } stim_row_t;

    // target change, target, number, last, typed result, way_count, sum_too_large
    stim_row_t stim_table [22] = '{
        '{1'b1,     0,    5, 1'b1, 1'b1, 0, 1'b0},
        '{1'b0,     0,    0, 1'b1, 1'b1, 2, 1'b0},
        '{1'b0,     0,    3, 1'b0, 1'b0, 0, 1'b0},
        '{1'b0,     0,    3, 1'b1, 1'b1, 2, 1'b0},
        '{1'b0,     0, 1023, 1'b0, 1'b0, 0, 1'b0},
        '{1'b0,     0, 1023, 1'b0, 1'b0, 0, 1'b0},
        '{1'b0,     0, 1023, 1'b1, 1'b1, 0, 1'b0},
        '{1'b0,     0, 1023, 1'b0, 1'b0, 0, 1'b0},
        '{1'b0,     0, 1023, 1'b1, 1'b1, 2, 1'b0},
        '{1'b1,  1023,    1, 1'b1, 1'b1, 0, 1'b0},
        '{1'b0,  1023, 1023, 1'b1, 1'b1, 1, 1'b0},
        '{1'b1, -1023, 1022, 1'b1, 1'b1, 0, 1'b0},
        '{1'b0, -1023, 1023, 1'b1, 1'b1, 1, 1'b0},
        '{1'b0, -1023,  512, 1'b0, 1'b0, 0, 1'b0},
        '{1'b0, -1023,  511, 1'b0, 1'b0, 0, 1'b0},
        '{1'b0, -1023,    1, 1'b1, 1'b1, 0, 1'b0},
        '{1'b0, -1023,    7, 1'b0, 1'b0, 0, 1'b0},
        '{1'b0, -1023,    0, 1'b0, 1'b0, 0, 1'b0},
        '{1'b0, -1023, 1016, 1'b1, 1'b0, 0, 1'b0},
        '{1'b1,     1,    1, 1'b0, 1'b0, 0, 1'b0},
        '{1'b0,     1,    2, 1'b0, 1'b0, 0, 1'b0},
        '{1'b0,     1,    0, 1'b1, 1'b0, 0, 1'b0}
    };

    logic                              aclk        = 1'b0;
    logic                              aresetn     = 1'b0;
    logic                              cfg_wr_en   = 1'b0;
    logic signed [tswc_pkg::TGT_W-1:0] cfg_wr_data = '0;
    logic                              s_valid     = 1'b0;
    logic                              s_ready;
    tswc_pkg::in_item_t                s_data      = '0;
    logic                              m_valid;
    logic                              m_ready     = 1'b0;
    tswc_pkg::out_item_t               m_data;

    tswc_pkg::count_t    ways_row [0:tswc_pkg::MAX_SUM];
    int                  set_total;
    bit                  set_saturated;
    int                  target_now;
    tswc_pkg::out_item_t ways_due [$];
    tswc_pkg::out_item_t want;
    int                  src_gap_pct;
    int                  sink_stall_pct;
    int                  errors;
    int                  cycle_count;

    target_sum_way_counter uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void clear_set_state();
        foreach (ways_row[j]) ways_row[j] = '0;
        ways_row[0]   = tswc_pkg::count_t'(1);
        set_total     = 0;
        set_saturated = 1'b0;
    endfunction

    // in-place subset-count update from the top entry down
    function automatic void fold_number(int v);
        longint s;
        if (v <= tswc_pkg::MAX_SUM) begin
            for (int j = tswc_pkg::MAX_SUM; j >= v; j--) begin
                s = longint'(ways_row[j]) + longint'(ways_row[j - v]);
                if (s >= tswc_pkg::MODULUS) s -= tswc_pkg::MODULUS;
                ways_row[j] = tswc_pkg::count_t'(s);
            end
        end
        if (set_total + v > TOTAL_MAX) begin
            set_total     = TOTAL_MAX;
            set_saturated = 1'b1;
        end else begin
            set_total += v;
        end
    endfunction

    function automatic tswc_pkg::out_item_t close_set();
        tswc_pkg::out_item_t r;
        int d;
        r = '0;
        if (set_saturated) begin
            r.sum_too_large = 1'b1;
        end else if (target_now <= set_total && target_now >= -set_total) begin
            d = set_total + target_now;
            if (d % 2 == 0) begin
                if (d / 2 > tswc_pkg::MAX_SUM) r.sum_too_large = 1'b1;
                else r.way_count = ways_row[d / 2];
            end
        end
        clear_set_state();
        return r;
    endfunction

    task automatic send_number(input int v, input bit last, input bit typed,
                               input tswc_pkg::out_item_t canned);
        tswc_pkg::in_item_t it;
        tswc_pkg::out_item_t res;
        it.number_value = v[tswc_pkg::NUM_W-1:0];
        it.last_number  = last;
        if ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_gap_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        fold_number(v);
        if (last) begin
            res = close_set();
            ways_due.push_back(typed ? canned : res);
        end
    endtask

    // sender holds off until every count is back and the clearing pass is over
    task automatic drain_pause();
        s_valid <= 1'b0;
        while (ways_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_target(input int t);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= tswc_pkg::TGT_W'(t);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        target_now = t;
    endtask

    function automatic int pick_number();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 0;
        if (r < 45) return $urandom_range(20, 1);
        if (r < 65) return $urandom_range(1023, 21);
        if (r < 80) return $urandom_range(1023, 900);
        return $urandom_range(1023);
    endfunction

    // dense sets are long runs of zeros and values 1 to 3 pushing counts past the modulus
    task automatic feed_set(input bit dense, output int n);
        int len;
        int v;
        int tot;
        len = dense ? $urandom_range(36, 30) : $urandom_range(6, 1);
        tot = 0;
        for (int k = 0; k < len; k++) begin
            if (dense) v = ($urandom_range(99) < 70) ? 0 : $urandom_range(3, 1);
            else v = pick_number();
            if (k == len - 1 && $urandom_range(99) < 60 && (tot + v + target_now) % 2 != 0)
                v = v ^ 1;
            tot += v;
            send_number(v, k == len - 1, 1'b0, '0);
        end
        n = len;
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (ways_due.size() == 0) begin
                $error("unexpected item way_count %0d sum_too_large %0b",
                       m_data.way_count, m_data.sum_too_large);
                errors++;
            end else begin
                want = ways_due.pop_front();
                if (m_data.way_count !== want.way_count) begin
                    $error("way_count expected %0d actual %0d",
                           want.way_count, m_data.way_count);
                    errors++;
                end
                if (m_data.sum_too_large !== want.sum_too_large) begin
                    $error("sum_too_large expected %0b actual %0b",
                           want.sum_too_large, m_data.sum_too_large);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        tswc_pkg::out_item_t canned;
        int phase_items;
        int n;
        int t;
        errors         = 0;
        target_now     = 0;
        src_gap_pct    = 13;
        sink_stall_pct = 46;
        clear_set_state();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[i]) begin
            if (stim_table[i].new_tgt) begin
                drain_pause();
                set_target(stim_table[i].tgt);
            end
            canned.way_count     = stim_table[i].cnt[tswc_pkg::COUNT_W-1:0];
            canned.sum_too_large = stim_table[i].flag;
            send_number(stim_table[i].num, stim_table[i].last, stim_table[i].typed, canned);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 2) begin
                src_gap_pct    = 13;
                sink_stall_pct = 46;
            end else if (ph < 4) begin
                src_gap_pct    = 46;
                sink_stall_pct = 13;
            end else begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            case (ph)
                0: t = 1023;
                1: t = -1023;
                2: t = 0;
                3: t = int'($urandom_range(2046)) - 1023;
                4: t = int'($urandom_range(40)) - 20;
                default: t = 2;
            endcase
            drain_pause();
            set_target(t);
            feed_set(1'b1, n);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                feed_set(1'b0, n);
                phase_items += n;
            end
        end

        drain_pause();
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

/* sim.f */
sv/tswc_pkg.sv
sv/tswc_ram.sv
sv/tswc_mod_add.sv
sv/tswc_judge.sv
sv/target_sum_way_counter.sv
verif/tb.sv
